// ----- rtl/psrp_pkg.sv -----
// Shared types and constants of the position-sensitive ROI pooling core.
package psrp_pkg;

  localparam int unsigned MAX_ROWS     = 32;
  localparam int unsigned MAX_COLS     = 32;
  localparam int unsigned MAX_CHANNELS = 64;
  localparam int unsigned ROW_W        = $clog2(MAX_ROWS);
  localparam int unsigned COL_W        = $clog2(MAX_COLS);
  localparam int unsigned CH_W         = $clog2(MAX_CHANNELS);
  localparam int unsigned ADDR_W       = CH_W + ROW_W + COL_W;
  localparam int unsigned STORE_DEPTH  = MAX_CHANNELS * MAX_ROWS * MAX_COLS;
  localparam int unsigned CELL_CNT_W   = $clog2(MAX_ROWS * MAX_COLS + 1);
  // sum of up to MAX_ROWS*MAX_COLS 16-bit values, plus sign
  localparam int unsigned SUM_MAG_W    = 15 + CELL_CNT_W;
  localparam int unsigned SUM_W        = SUM_MAG_W + 1;
  localparam logic signed [15:0] MAX_FLOOR = -16'sd128;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 3'd5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POOL = 1'b1;

  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_AVG = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [5:0]         load_channel;
    logic [4:0]         load_row;
    logic [4:0]         load_col;
    logic signed [15:0] load_value;
    logic signed [7:0]  start_row;
    logic signed [7:0]  start_col;
    logic [12:0]        bin_height;
    logic [12:0]        bin_width;
    logic [2:0]         bin_row;
    logic [2:0]         bin_col;
    logic [5:0]         class_index;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pooled;
    logic               window_empty;
  } out_word_t;

endpackage

// ----- rtl/position_sensitive_roi_pooling_core.sv -----
// Position-sensitive ROI pooling core: feature store, window walker and divider.
// A load word writes one feature value; busy_o stays low so loads may follow
// back to back. In max mode a pool word passes through a setup state, one store
// read per cell of the clamped window (single read port), a state to drain the
// last read and a state to finish; the result is then registered and shown.
// Average mode adds a bit-serial divide by the cell count. An empty window, or
// a channel past the store, returns straight from the setup state. The result
// is shown for one cycle with done_o; the receiver cannot stall it, and the next
// word may be accepted in that cycle. Store entries never loaded read as
// undefined.
module position_sensitive_roi_pooling_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  psrp_pkg::in_word_t                 in_i,
  output logic                               done_o,
  output psrp_pkg::out_word_t                res_o,
  input  logic                               cfg_we_i,
  input  logic [psrp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [psrp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_WALK, ST_DRAIN, ST_POST, ST_DIV
  } state_e;

  localparam int unsigned DIV_CNT_W = $clog2(psrp_pkg::SUM_MAG_W);
  localparam int unsigned REM_W     = psrp_pkg::CELL_CNT_W;

  // configuration
  logic       mode_q;
  logic [5:0] map_h_q, map_w_q;
  logic [3:0] pool_h_q, pool_w_q;
  logic [6:0] class_cnt_q;

  // feature store
  logic [15:0] mem [psrp_pkg::STORE_DEPTH];
  logic [15:0] rdata_q;
  logic        mem_we;
  logic [psrp_pkg::ADDR_W-1:0] waddr, raddr;

  state_e state_q, state_d;
  psrp_pkg::in_word_t qry_q;
  logic [5:0]  h1_q, w0_q, w1_q, h_q, w_q;
  logic [psrp_pkg::CH_W-1:0] chan_q;
  logic        rd_pend_q;
  logic signed [psrp_pkg::SUM_W-1:0] sum_q;
  logic signed [15:0] best_q;
  logic [psrp_pkg::CELL_CNT_W-1:0] count_q;
  logic [psrp_pkg::SUM_MAG_W-1:0] quo_q;
  logic [REM_W-1:0] rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic        neg_q;
  logic        done_q;
  psrp_pkg::out_word_t res_q;

  // window setup
  logic [15:0] a_row_full, a_col_full;
  logic [16:0] b_row_full, b_col_full;
  logic [5:0]  hlim, wlim, h0_c, h1_c, w0_c, w1_c;
  logic [14:0] chan_full;
  logic        empty_c;

  // divider step
  logic [REM_W:0] rem_sh;
  logic           rem_ge;

  function automatic logic [5:0] clamp_axis(input logic [10:0] v, input logic [5:0] lim);
    logic signed [10:0] s;
    s = $signed(v);
    if (s < 0) begin
      clamp_axis = 6'd0;
    end else if (s > $signed({5'd0, lim})) begin
      clamp_axis = lim;
    end else begin
      clamp_axis = v[5:0];
    end
  endfunction

  assign mem_we = start_i && !busy_o && (in_i.operation == psrp_pkg::OP_LOAD);
  assign waddr  = {in_i.load_channel[psrp_pkg::CH_W-1:0], in_i.load_row[psrp_pkg::ROW_W-1:0],
                   in_i.load_col[psrp_pkg::COL_W-1:0]};
  assign raddr  = {chan_q, h_q[psrp_pkg::ROW_W-1:0], w_q[psrp_pkg::COL_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= in_i.load_value;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    hlim = (map_h_q > 6'(psrp_pkg::MAX_ROWS)) ? 6'(psrp_pkg::MAX_ROWS) : map_h_q;
    wlim = (map_w_q > 6'(psrp_pkg::MAX_COLS)) ? 6'(psrp_pkg::MAX_COLS) : map_w_q;
    a_row_full = 16'(qry_q.bin_row) * 16'(qry_q.bin_height);
    a_col_full = 16'(qry_q.bin_col) * 16'(qry_q.bin_width);
    b_row_full = 17'({1'b0, qry_q.bin_row} + 4'd1) * 17'(qry_q.bin_height) + 17'd255;
    b_col_full = 17'({1'b0, qry_q.bin_col} + 4'd1) * 17'(qry_q.bin_width) + 17'd255;
    h0_c = clamp_axis(11'({3'd0, a_row_full[15:8]}) + 11'($signed(qry_q.start_row)), hlim);
    h1_c = clamp_axis(11'({2'd0, b_row_full[16:8]}) + 11'($signed(qry_q.start_row)), hlim);
    w0_c = clamp_axis(11'({3'd0, a_col_full[15:8]}) + 11'($signed(qry_q.start_col)), wlim);
    w1_c = clamp_axis(11'({2'd0, b_col_full[16:8]}) + 11'($signed(qry_q.start_col)), wlim);
    chan_full = (15'(qry_q.bin_row) * 15'(pool_w_q) + 15'(qry_q.bin_col)) * 15'(class_cnt_q)
                + 15'(qry_q.class_index);
    empty_c = (h1_c <= h0_c) || (w1_c <= w0_c) || (chan_full >= 15'(psrp_pkg::MAX_CHANNELS));
  end

  assign rem_sh = {rem_q, quo_q[psrp_pkg::SUM_MAG_W-1]};
  assign rem_ge = rem_sh >= (REM_W+1)'(count_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i && in_i.operation == psrp_pkg::OP_POOL) state_d = ST_SETUP;
      ST_SETUP: state_d = empty_c ? ST_IDLE : ST_WALK;
      ST_WALK:  if ((w_q + 6'd1 == w1_q) && (h_q + 6'd1 == h1_q)) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_POST;
      ST_POST:  state_d = (mode_q == psrp_pkg::MODE_AVG) ? ST_DIV : ST_IDLE;
      ST_DIV:   if (div_cnt_q == '0) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= psrp_pkg::MODE_MAX;
      map_h_q     <= 6'd32;
      map_w_q     <= 6'd32;
      pool_h_q    <= 4'd3;
      pool_w_q    <= 4'd3;
      class_cnt_q <= 7'd7;
      rd_pend_q   <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      done_q    <= 1'b0;
      rd_pend_q <= (state_q == ST_WALK);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          psrp_pkg::REG_POOL_MODE:   mode_q      <= cfg_data_i[0];
          psrp_pkg::REG_MAP_HEIGHT:  map_h_q     <= cfg_data_i[5:0];
          psrp_pkg::REG_MAP_WIDTH:   map_w_q     <= cfg_data_i[5:0];
          psrp_pkg::REG_POOL_HEIGHT: pool_h_q    <= cfg_data_i[3:0];
          psrp_pkg::REG_POOL_WIDTH:  pool_w_q    <= cfg_data_i[3:0];
          psrp_pkg::REG_CLASS_COUNT: class_cnt_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        qry_q <= in_i;
      end
      if (rd_pend_q) begin
        sum_q   <= sum_q + psrp_pkg::SUM_W'($signed(rdata_q));
        count_q <= count_q + 1'b1;
        if ($signed(rdata_q) > best_q) best_q <= $signed(rdata_q);
      end
      case (state_q)
        ST_SETUP: begin
          h1_q    <= h1_c;
          w0_q    <= w0_c;
          w1_q    <= w1_c;
          h_q     <= h0_c;
          w_q     <= w0_c;
          chan_q  <= chan_full[psrp_pkg::CH_W-1:0];
          sum_q   <= '0;
          count_q <= '0;
          best_q  <= psrp_pkg::MAX_FLOOR;
          if (empty_c) begin
            res_q.pooled       <= '0;
            res_q.window_empty <= 1'b1;
            done_q             <= 1'b1;
          end
        end
        ST_WALK: begin
          if (w_q + 6'd1 == w1_q) begin
            w_q <= w0_q;
            h_q <= h_q + 6'd1;
          end else begin
            w_q <= w_q + 6'd1;
          end
        end
        ST_POST: begin
          res_q.window_empty <= 1'b0;
          neg_q     <= sum_q[psrp_pkg::SUM_W-1];
          quo_q     <= psrp_pkg::SUM_MAG_W'(sum_q[psrp_pkg::SUM_W-1] ? -sum_q : sum_q);
          rem_q     <= '0;
          div_cnt_q <= DIV_CNT_W'(psrp_pkg::SUM_MAG_W - 1);
          if (mode_q == psrp_pkg::MODE_MAX) begin
            res_q.pooled <= best_q;
            done_q       <= 1'b1;
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          quo_q     <= {quo_q[psrp_pkg::SUM_MAG_W-2:0], rem_ge};
          rem_q     <= rem_ge ? REM_W'(rem_sh - (REM_W+1)'(count_q)) : rem_sh[REM_W-1:0];
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == '0) begin
            res_q.pooled <= neg_q ? -16'($unsigned({quo_q[psrp_pkg::SUM_MAG_W-2:0], rem_ge}))
                                  :  16'($unsigned({quo_q[psrp_pkg::SUM_MAG_W-2:0], rem_ge}));
            done_q       <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without a pool word in flight");
  a_read_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(state_q == ST_WALK)) else $error("read data outside walk");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.window_empty) |-> (res_o.pooled == 16'sd0))
    else $error("empty window with nonzero result");
  a_walk_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((h_q < h1_q) && (w_q < w1_q)))
    else $error("walk address left the window");
`endif

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench of the position-sensitive ROI pooling core.
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT = 4000000;
  // rows and columns per channel that the directed fill loads
  localparam int FILL = 4;
  localparam logic [psrp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [psrp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    psrp_pkg::in_word_t  w;
    bit                  chk;
    psrp_pkg::out_word_t exp;
  } row_t;

  logic clk_i, rst_ni;
  logic start_i, busy_o, done_o;
  psrp_pkg::in_word_t in_i;
  psrp_pkg::out_word_t res_o;
  logic cfg_we_i;
  logic [psrp_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [psrp_pkg::CFG_DATA_W-1:0] cfg_data_i;

  position_sensitive_roi_pooling_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o), .in_i(in_i),
    .done_o(done_o), .res_o(res_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // shadow of the block's state
  logic signed [15:0] fmap [psrp_pkg::STORE_DEPTH];
  bit         written [psrp_pkg::STORE_DEPTH];
  logic       mode_q;
  logic [5:0] map_h_q, map_w_q;
  logic [3:0] pool_h_q, pool_w_q;
  logic [6:0] cls_cnt_q;

  psrp_pkg::out_word_t pooled_q[$];
  int errors = 0;
  int cycles = 0;
  row_t rows[$];

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic expect_word(psrp_pkg::out_word_t e);
    pooled_q = {pooled_q, e};
  endtask

  task automatic add_row(psrp_pkg::in_word_t w, bit chk = 0,
                         psrp_pkg::out_word_t exp = '0);
    row_t r;
    r.w = w;
    r.chk = chk;
    r.exp = exp;
    rows = {rows, r};
  endtask

  function automatic void axis(int bin, int size, int st, int lim, output int lo, output int hi);
    int a, b;
    a = (bin * size) >>> 8;
    b = ((bin + 1) * size + 255) >>> 8;
    lo = a + st;
    hi = b + st;
    lo = lo < 0 ? 0 : (lo > lim ? lim : lo);
    hi = hi < 0 ? 0 : (hi > lim ? lim : hi);
  endfunction

  function automatic int chan_of(psrp_pkg::in_word_t w);
    return (int'(w.bin_row) * int'(pool_w_q) + int'(w.bin_col)) * int'(cls_cnt_q)
           + int'(w.class_index);
  endfunction

  function automatic void window(psrp_pkg::in_word_t w, output int h0, output int h1,
                                 output int c0, output int c1);
    int hl, wl;
    hl = map_h_q < psrp_pkg::MAX_ROWS ? int'(map_h_q) : psrp_pkg::MAX_ROWS;
    wl = map_w_q < psrp_pkg::MAX_COLS ? int'(map_w_q) : psrp_pkg::MAX_COLS;
    axis(w.bin_row, w.bin_height, $signed(w.start_row), hl, h0, h1);
    axis(w.bin_col, w.bin_width, $signed(w.start_col), wl, c0, c1);
  endfunction

  // true when the pool word reads only entries that were loaded
  function automatic bit covered(psrp_pkg::in_word_t w);
    int h0, h1, c0, c1, chan;
    window(w, h0, h1, c0, c1);
    chan = chan_of(w);
    if ((h1 <= h0) || (c1 <= c0) || (chan >= psrp_pkg::MAX_CHANNELS)) return 1'b1;
    for (int h = h0; h < h1; h++)
      for (int c = c0; c < c1; c++)
        if (!written[(chan * psrp_pkg::MAX_ROWS + h) * psrp_pkg::MAX_COLS + c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic psrp_pkg::out_word_t pool_predict(psrp_pkg::in_word_t w);
    int h0, h1, c0, c1, chan, best;
    longint sum, cnt;
    psrp_pkg::out_word_t r;
    window(w, h0, h1, c0, c1);
    chan = chan_of(w);
    r.pooled = '0;
    r.window_empty = (h1 <= h0) || (c1 <= c0) || (chan >= psrp_pkg::MAX_CHANNELS);
    if (!r.window_empty) begin
      best = psrp_pkg::MAX_FLOOR;
      sum = 0;
      cnt = 0;
      for (int h = h0; h < h1; h++)
        for (int c = c0; c < c1; c++) begin
          int v;
          v = fmap[(chan * psrp_pkg::MAX_ROWS + h) * psrp_pkg::MAX_COLS + c];
          if (v > best) best = v;
          sum += v;
          cnt++;
        end
      r.pooled = (mode_q == psrp_pkg::MODE_AVG) ? 16'(sum / cnt) : 16'(best);
    end
    return r;
  endfunction

  task automatic send(psrp_pkg::in_word_t w, int gap, bit chk = 0,
                      psrp_pkg::out_word_t exp = '0);
    psrp_pkg::out_word_t p;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= w;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    if (w.operation == psrp_pkg::OP_LOAD) begin
      fmap[{w.load_channel, w.load_row, w.load_col}] = w.load_value;
      written[{w.load_channel, w.load_row, w.load_col}] = 1'b1;
    end else begin
      p = pool_predict(w);
      if (chk && p != exp) report($sformatf("typed row disagrees with predictor %h", w));
      expect_word(chk ? exp : p);
    end
  endtask

  // drain all results, then let the block settle before config writes
  task automatic go_idle();
    start_i <= 1'b0;
    while (pooled_q.size() > 0) @(negedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [psrp_pkg::CFG_IDX_W-1:0] idx,
                           logic [psrp_pkg::CFG_DATA_W-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      psrp_pkg::REG_POOL_MODE:   mode_q = d[0];
      psrp_pkg::REG_MAP_HEIGHT:  map_h_q = d[5:0];
      psrp_pkg::REG_MAP_WIDTH:   map_w_q = d[5:0];
      psrp_pkg::REG_POOL_HEIGHT: pool_h_q = d[3:0];
      psrp_pkg::REG_POOL_WIDTH:  pool_w_q = d[3:0];
      psrp_pkg::REG_CLASS_COUNT: cls_cnt_q = d;
      default: ;
    endcase
  endtask

  function automatic psrp_pkg::in_word_t rand_word();
    psrp_pkg::in_word_t w;
    w = psrp_pkg::in_word_t'($bits(psrp_pkg::in_word_t)'({$urandom, $urandom, $urandom}));
    return w;
  endfunction

  function automatic psrp_pkg::in_word_t mk_load(int ch, int r, int c, int v);
    psrp_pkg::in_word_t w;
    w = rand_word();
    w.operation = psrp_pkg::OP_LOAD;
    w.load_channel = 6'(ch);
    w.load_row = 5'(r);
    w.load_col = 5'(c);
    w.load_value = 16'(v);
    return w;
  endfunction

  function automatic psrp_pkg::in_word_t mk_pool(int sr, int sc, int bh, int bw, int br,
                                                 int bc, int cl);
    psrp_pkg::in_word_t w;
    w = rand_word();
    w.operation = psrp_pkg::OP_POOL;
    w.start_row = 8'(sr);
    w.start_col = 8'(sc);
    w.bin_height = 13'(bh);
    w.bin_width = 13'(bw);
    w.bin_row = 3'(br);
    w.bin_col = 3'(bc);
    w.class_index = 6'(cl);
    return w;
  endfunction

  function automatic psrp_pkg::in_word_t rand_item();
    psrp_pkg::in_word_t w;
    int k;
    w = rand_word();
    k = $urandom_range(0, 99);
    if (k < 40) begin
      w.operation = psrp_pkg::OP_LOAD;
      if ($urandom_range(0, 9) == 0) w.load_value = 16'(-$urandom_range(200, 32768));
      return w;
    end
    w.operation = psrp_pkg::OP_POOL;
    if (k < 43) return w;  // fully random, kept only when its window is loaded
    if (k < 50) begin
      w.bin_height = 13'($urandom_range(0, 8191) & 13'h03ff);
      w.bin_width = 13'($urandom_range(0, 8191) & 13'h03ff);
      return w;
    end
    w.start_row = 8'(int'($urandom_range(0, 7)) - 4);
    w.start_col = 8'(int'($urandom_range(0, 7)) - 4);
    w.bin_height = 13'($urandom_range(0, 'h180));
    w.bin_width = 13'($urandom_range(0, 'h180));
    w.bin_row = 3'($urandom_range(0, 3));
    w.bin_col = 3'($urandom_range(0, 3));
    if ($urandom_range(0, 3) != 0) begin
      w.bin_row = 3'($urandom_range(0, pool_h_q > 0 ? (pool_h_q > 8 ? 7 : pool_h_q - 1) : 0));
      w.bin_col = 3'($urandom_range(0, pool_w_q > 0 ? (pool_w_q > 8 ? 7 : pool_w_q - 1) : 0));
      w.class_index = 6'($urandom_range(0,
                         cls_cnt_q > 0 ? (cls_cnt_q > 64 ? 63 : cls_cnt_q - 1) : 0));
    end
    return w;
  endfunction

  // draw until a pool reads only loaded entries, else fall back to an empty window
  function automatic psrp_pkg::in_word_t pick_item();
    psrp_pkg::in_word_t w;
    w = rand_item();
    for (int t = 0; t < 50; t++) begin
      if (w.operation == psrp_pkg::OP_LOAD || covered(w)) return w;
      w = rand_item();
    end
    if (w.operation == psrp_pkg::OP_POOL && !covered(w)) w.bin_height = '0;
    return w;
  endfunction

  // results are checked at the falling edge, away from the driving edge
  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pooled_q.size() == 0) begin
        report($sformatf("unexpected word %h", res_o));
      end else begin
        psrp_pkg::out_word_t e;
        e = pooled_q.pop_front();
        if (res_o.pooled !== e.pooled)
          report($sformatf("pooled %0d, want %0d", res_o.pooled, e.pooled));
        if (res_o.window_empty !== e.window_empty)
          report($sformatf("window_empty %b, want %b", res_o.window_empty, e.window_empty));
      end
    end
  end

  initial begin
    int ph [8][6] = '{
      '{0, 32, 32, 3, 3, 7}, '{1, 32, 32, 3, 3, 7}, '{0, 1, 1, 1, 1, 1},
      '{1, 63, 63, 8, 8, 1}, '{0, 0, 32, 15, 15, 64}, '{1, 20, 12, 2, 2, 127},
      '{1, 32, 32, 1, 1, 0}, '{0, 17, 63, 8, 1, 4}};
    start_i = 0;
    in_i = '0;
    cfg_we_i = 0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    mode_q = psrp_pkg::MODE_MAX;
    map_h_q = 32;
    map_w_q = 32;
    pool_h_q = 3;
    pool_w_q = 3;
    cls_cnt_q = 7;
    rst_ni = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // load the top-left corner of every channel; pools are kept on loaded entries
    for (int ch = 0; ch < psrp_pkg::MAX_CHANNELS; ch++)
      for (int r = 0; r < FILL; r++)
        for (int c = 0; c < FILL; c++)
          send(mk_load(ch, r, c, $urandom), $urandom_range(0, 9));

    add_row(mk_load(0, 0, 0, -30000));
    add_row(mk_pool(0, 0, 'h100, 'h100, 0, 0, 0), 1, psrp_pkg::out_word_t'{-16'sd128, 1'b0});
    add_row(mk_load(0, 0, 0, 32767));
    add_row(mk_pool(0, 0, 'h100, 'h100, 0, 0, 0), 1, psrp_pkg::out_word_t'{16'sd32767, 1'b0});
    add_row(mk_load(0, 0, 0, -32768));
    add_row(mk_pool(0, 0, 'h100, 'h100, 0, 0, 0), 1, psrp_pkg::out_word_t'{-16'sd128, 1'b0});
    add_row(mk_pool(0, 0, 0, 0, 0, 0, 0), 1, psrp_pkg::out_word_t'{16'sd0, 1'b1});
    add_row(mk_pool(3, 3, 'h100, 'h100, 7, 7, 63), 1, psrp_pkg::out_word_t'{16'sd0, 1'b1});
    add_row(mk_pool(3, 3, 'h080, 'h080, 7, 7, 0), 1, psrp_pkg::out_word_t'{16'sd0, 1'b1});
    add_row(mk_pool(-128, 0, 'h100, 'h100, 0, 0, 0), 1, psrp_pkg::out_word_t'{16'sd0, 1'b1});
    add_row(mk_pool(127, 127, 'h100, 'h100, 0, 0, 0), 1, psrp_pkg::out_word_t'{16'sd0, 1'b1});
    add_row(mk_pool(-28, -28, 8191, 8191, 0, 0, 0));
    add_row(mk_load(63, 31, 31, -1));
    add_row(mk_load(63, 30, 30, -5));
    add_row(mk_load(63, 31, 30, 100));
    add_row(mk_pool(31, 31, 'h100, 'h100, 0, 0, 63));
    add_row(mk_pool(30, 30, 'h1ff, 'h081, 0, 0, 63));
    add_row(mk_pool(-5, 1, 'h0800, 'h0180, 0, 1, 2));
    foreach (rows[i]) send(rows[i].w, $urandom_range(0, 9), rows[i].chk, rows[i].exp);

    for (int p = 0; p < 8; p++) begin
      go_idle();
      cfg_write(psrp_pkg::REG_POOL_MODE, psrp_pkg::CFG_DATA_W'(ph[p][0]));
      cfg_write(psrp_pkg::REG_MAP_HEIGHT, psrp_pkg::CFG_DATA_W'(ph[p][1]));
      cfg_write(psrp_pkg::REG_MAP_WIDTH, psrp_pkg::CFG_DATA_W'(ph[p][2]));
      cfg_write(psrp_pkg::REG_POOL_HEIGHT, psrp_pkg::CFG_DATA_W'(ph[p][3]));
      cfg_write(psrp_pkg::REG_POOL_WIDTH, psrp_pkg::CFG_DATA_W'(ph[p][4]));
      cfg_write(psrp_pkg::REG_CLASS_COUNT, psrp_pkg::CFG_DATA_W'(ph[p][5]));
      if (p == 0) begin
        cfg_write(REG_SPARE_LO, 7'h7f);  // unknown indexes are ignored
        cfg_write(REG_SPARE_HI, 7'h00);
      end
      for (int i = 0; i < 64; i++)
        send(pick_item(), $urandom_range(0, 9));
    end

    go_idle();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
